>>> design/fsktx_pkg.sv
package fsktx_pkg;

  localparam int DATA_W    = 16;
  localparam int CFG_W     = 24;
  localparam int DBITS_W   = 5;
  localparam int IDX_W     = 5;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_DATA_BITS_DEF = 16;
  localparam int COUNT_WIDTH_DEF   = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_HALF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PILOT_HALF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_HALF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BITS     = 3'd4;

  localparam logic [CFG_W-1:0]   PREAMBLE_HALF_RST = 24'd96;
  localparam logic [CFG_W-1:0]   PILOT_HALF_RST    = 24'd59;
  localparam logic [CFG_W-1:0]   DEFAULT_HALF_RST  = 24'd166;
  localparam logic [CFG_W-1:0]   BIT_PERIOD_RST    = 24'd12500;
  localparam logic [DBITS_W-1:0] DATA_BITS_RST     = 5'd16;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] data;
  } in_t;

  typedef struct packed {
    logic led_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } out_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

endpackage

>>> design/fsktx_core.sv
module fsktx_core #(
  parameter int MAX_DATA_BITS = fsktx_pkg::MAX_DATA_BITS_DEF,
  parameter int COUNT_WIDTH   = fsktx_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  fsktx_pkg::cfg_wr_t cfg_wr,
  input  logic               step,
  input  fsktx_pkg::in_t     item,
  output fsktx_pkg::out_t    result
);

  localparam int CMP_W = (COUNT_WIDTH > fsktx_pkg::CFG_W) ? COUNT_WIDTH : fsktx_pkg::CFG_W;
  localparam int NB_W  = 7;
  localparam logic [NB_W-1:0] MAXB = NB_W'(MAX_DATA_BITS);

  logic [fsktx_pkg::CFG_W-1:0]   preamble_half;
  logic [fsktx_pkg::CFG_W-1:0]   pilot_half;
  logic [fsktx_pkg::CFG_W-1:0]   default_half;
  logic [fsktx_pkg::CFG_W-1:0]   symbol_len;
  logic [fsktx_pkg::DBITS_W-1:0] data_bits;

  logic                          line_level, line_level_next;
  logic [COUNT_WIDTH-1:0]        toggle_ticks, toggle_ticks_next;
  logic [COUNT_WIDTH-1:0]        symbol_ticks, symbol_ticks_next;
  logic [fsktx_pkg::IDX_W-1:0]   symbol_index, symbol_index_next;
  logic [fsktx_pkg::DATA_W-1:0]  data_shift, data_shift_next;
  logic                          sending, sending_next;

  logic [NB_W-1:0]               nb;
  logic [NB_W-1:0]               idx_w;
  logic                          in_data_sym;
  logic [fsktx_pkg::CFG_W-1:0]   half;
  logic [fsktx_pkg::CFG_W-1:0]   per;
  logic [COUNT_WIDTH-1:0]        tt_inc, st_inc;
  logic [2*fsktx_pkg::DATA_W-1:0] wide_data;
  logic                          oversize;
  logic                          done, rej;

  always_comb begin
    if (data_bits == '0) begin
      nb = NB_W'(1);
    end else if (NB_W'(data_bits) > MAXB) begin
      nb = MAXB;
    end else begin
      nb = NB_W'(data_bits);
    end
  end

  assign idx_w       = NB_W'(symbol_index);
  assign in_data_sym = (idx_w >= NB_W'(2)) && (idx_w < nb + NB_W'(2));
  assign wide_data   = {{fsktx_pkg::DATA_W{1'b0}}, item.data};
  assign oversize    = (wide_data >> nb) != '0;
  assign per         = (symbol_len == '0) ? fsktx_pkg::CFG_W'(1) : symbol_len;
  assign tt_inc      = (toggle_ticks == '1) ? toggle_ticks : toggle_ticks + 1'b1;
  assign st_inc      = (symbol_ticks == '1) ? symbol_ticks : symbol_ticks + 1'b1;

  always_comb begin
    priority if (symbol_index == '0) begin
      half = preamble_half;
    end else if (idx_w == NB_W'(1)) begin
      half = pilot_half;
    end else if (idx_w < nb + NB_W'(2)) begin
      half = data_shift[0] ? pilot_half : default_half;
    end else begin
      half = default_half;
    end
  end

  always_comb begin
    line_level_next   = line_level;
    toggle_ticks_next = toggle_ticks;
    symbol_ticks_next = symbol_ticks;
    symbol_index_next = symbol_index;
    data_shift_next   = data_shift;
    sending_next      = sending;
    done              = 1'b0;
    rej               = 1'b0;
    if (item.mode == fsktx_pkg::MODE_START) begin
      if (sending || oversize) begin
        rej = 1'b1;
      end else begin
        data_shift_next   = item.data;
        symbol_index_next = '0;
        symbol_ticks_next = '0;
        sending_next      = 1'b1;
      end
    end else if (!sending) begin
      toggle_ticks_next = tt_inc;
    end else begin
      toggle_ticks_next = tt_inc;
      if (CMP_W'(tt_inc) >= CMP_W'(half)) begin
        line_level_next   = ~line_level;
        toggle_ticks_next = '0;
      end
      symbol_ticks_next = st_inc;
      if (CMP_W'(st_inc) >= CMP_W'(per)) begin
        symbol_ticks_next = '0;
        if (in_data_sym) begin
          data_shift_next = data_shift >> 1;
        end
        if (idx_w + NB_W'(1) >= nb + NB_W'(4)) begin
          sending_next      = 1'b0;
          symbol_index_next = '0;
          done              = 1'b1;
        end else begin
          symbol_index_next = symbol_index + 1'b1;
        end
      end
    end
  end

  always_comb begin
    result.led_level  = line_level_next;
    result.busy_res   = sending_next;
    result.frame_done = done;
    result.rejected   = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_half <= fsktx_pkg::PREAMBLE_HALF_RST;
      pilot_half    <= fsktx_pkg::PILOT_HALF_RST;
      default_half  <= fsktx_pkg::DEFAULT_HALF_RST;
      symbol_len    <= fsktx_pkg::BIT_PERIOD_RST;
      data_bits     <= fsktx_pkg::DATA_BITS_RST;
    end else if (cfg_wr.we) begin
      unique case (cfg_wr.index)
        fsktx_pkg::REG_PREAMBLE_HALF: preamble_half <= cfg_wr.data;
        fsktx_pkg::REG_PILOT_HALF:    pilot_half    <= cfg_wr.data;
        fsktx_pkg::REG_DEFAULT_HALF:  default_half  <= cfg_wr.data;
        fsktx_pkg::REG_BIT_PERIOD:    symbol_len    <= cfg_wr.data;
        fsktx_pkg::REG_DATA_BITS:     data_bits     <= cfg_wr.data[fsktx_pkg::DBITS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_level   <= 1'b0;
      toggle_ticks <= '0;
      symbol_ticks <= '0;
      symbol_index <= '0;
      data_shift   <= '0;
      sending      <= 1'b0;
    end else if (step) begin
      line_level   <= line_level_next;
      toggle_ticks <= toggle_ticks_next;
      symbol_ticks <= symbol_ticks_next;
      symbol_index <= symbol_index_next;
      data_shift   <= data_shift_next;
      sending      <= sending_next;
    end
  end

endmodule

>>> design/fsk_frame_tone_transmitter.sv
// Binary FSK frame sender on one LED line. Each input word is either a timer tick or a
// frame start carrying up to sixteen data bits; every word yields exactly one result word
// with the line level, busy flag, frame-done flag and reject flag. One word is accepted
// per clock when the output is not stalled. The word is held in an input register,
// then one pass of counter updates and compares writes the frame state and the result
// register. Configuration writes are always ready.
module fsk_frame_tone_transmitter #(
  parameter int MAX_DATA_BITS = fsktx_pkg::MAX_DATA_BITS_DEF,
  parameter int COUNT_WIDTH   = fsktx_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fsktx_pkg::in_t                      in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fsktx_pkg::out_t                     out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fsktx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fsktx_pkg::CFG_W-1:0]         cfg_data
);

  logic               hold_valid;
  fsktx_pkg::in_t     hold_item;
  logic               advance;
  fsktx_pkg::out_t    result;
  fsktx_pkg::cfg_wr_t cfg_wr;

  assign cfg_ready = 1'b1;
  assign advance   = hold_valid && (!out_valid || !out_stall);
  assign in_stall  = hold_valid && !advance;

  always_comb begin
    cfg_wr.we    = cfg_valid && cfg_ready;
    cfg_wr.index = cfg_index;
    cfg_wr.data  = cfg_data;
  end

  fsktx_core #(
    .MAX_DATA_BITS(MAX_DATA_BITS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg_wr(cfg_wr),
    .step  (advance),
    .item  (hold_item),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_item <= in_item;
    end
    if (advance) begin
      out_item <= result;
    end
  end

endmodule

>>> design/fsktx_checker.sv
module fsktx_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_stall,
  input fsktx_pkg::out_t out_item
);

  // A frame that has just ended cannot still be busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.frame_done |-> !out_item.busy_res)
    else $error("frame_done with busy_res set");

  // A refused start is never also the end of a frame.
  a_reject_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.rejected |-> !out_item.frame_done)
    else $error("rejected and frame_done both set");

  // Reset clears the result valid flag, so no result shows in the cycle after it.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result word changed");

endmodule

bind fsk_frame_tone_transmitter fsktx_checker u_fsktx_checker (.*);
